/* sv/rars_pkg.sv */
// ----------------------------------------------------------------------------
// rars_pkg - shared constants for the range add / range sum store
// Field widths, command codes and default capacity.
// ----------------------------------------------------------------------------
package rars_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int DATA_W       = 64;
  localparam int IDX_W        = 10;
  localparam int CFG_W        = 11;
  localparam int IN_TDATA_W   = 88;   // 10 + 10 + 64 = 84, padded to bytes

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_SUM = 1'b1;

endpackage

/* sv/range_add_range_sum_tree.sv */
// ----------------------------------------------------------------------------
// range_add_range_sum_tree - range add / range sum over signed 64-bit elements
// Two Fenwick trees packed in one RAM keep the difference array and its
// index-weighted copy; sums wrap modulo 2^64.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction per command. in_tuser is the command (0 add,
//           1 sum query); in_tdata holds low_index, high_index, add_value.
//   out_* : one transaction per query with the 64-bit wrapped sum.
//   cfg_* : writes size_in_use (clamped to 1..CAPACITY) and clears the store.
// Operation:
//   An add walks the tree at the low index and, unless the high index is
//   the last one in use, once more past the high index. Each walk forms the
//   weight in the multiplier (ST_ULO, ST_UHI), then reads and writes each
//   visited entry (ST_URD, ST_UWR), at most log2(N)+1 entries. A query walks
//   two prefixes (ST_QRD, ST_QACC per entry, at most 10 at N = 1024), scales
//   and combines each (ST_QLO, ST_QHI, ST_QFIN), then loads the result
//   (ST_OUT); in_tready returns high after that. One command is in flight.
// Reset and configuration:
//   After reset, and after every configuration write, a clearing pass writes
//   zero to all CAPACITY+1 RAM entries, one per cycle; in_tready stays low.
// Stall:
//   A finished result waits in the output register; the next command is
//   taken meanwhile, and a query only holds at its end if it is still full.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree #(
  parameter int CAPACITY = rars_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [rars_pkg::IN_TDATA_W-1:0] in_tdata,  // low_index, high_index, add_value
  input  logic                          in_tuser,  // cmd
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [rars_pkg::DATA_W-1:0]   out_tdata, // range_sum
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rars_pkg::CFG_W-1:0]    cfg_data   // size_in_use
);

  localparam int DW    = rars_pkg::DATA_W;
  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(CAPACITY + 1);
  localparam int IW    = SW + 1;
  localparam int MW    = 32 + IW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_ULO  = 4'd2;
  localparam logic [3:0] ST_UHI  = 4'd3;
  localparam logic [3:0] ST_URD  = 4'd4;
  localparam logic [3:0] ST_UWR  = 4'd5;
  localparam logic [3:0] ST_QRD  = 4'd6;
  localparam logic [3:0] ST_QACC = 4'd7;
  localparam logic [3:0] ST_QLO  = 4'd8;
  localparam logic [3:0] ST_QHI  = 4'd9;
  localparam logic [3:0] ST_QFIN = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic          pass_r, pass_nxt;
  logic          two_r, two_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] p_r, p_nxt;     // update position or prefix length
  logic [IW-1:0] a_r, a_nxt;
  logic [IW-1:0] b1_r, b1_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [DW-1:0] valp_r, valp_nxt;
  logic [DW-1:0] acc1_r, acc1_nxt;
  logic [DW-1:0] acc2_r, acc2_nxt;
  logic [DW-1:0] lo_r, lo_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic          ov_r, ov_nxt;
  logic [DW-1:0] od_r, od_nxt;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [2*DW-1:0]   wdata, rdata;
  logic [31:0]       mul_a;
  logic [MW-1:0]     mul_p;
  logic [IW-1:0]     lowbit;
  logic [IW-1:0]     i_up, i_dn;
  logic [DW-1:0]     pre;
  logic [31:0]       cfg32, a32, b32, last32, bc32;
  logic              empty;

  rars_ram #(.WIDTH(2 * DW), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // One 32 x IW multiplier, shared by update weight and prefix scaling.
  assign mul_p  = MW'(mul_a) * MW'(p_r);
  assign lowbit = i_r & (~i_r + IW'(1));
  assign i_up   = i_r + lowbit;
  assign i_dn   = i_r - lowbit;
  assign pre    = lo_r + {mul_p[31:0], 32'd0} - acc2_r;

  assign cfg32  = 32'(cfg_data);
  assign a32    = 32'(in_tdata[9:0]);
  assign b32    = 32'(in_tdata[19:10]);
  assign last32 = 32'(size_r) - 32'd1;
  assign bc32   = (b32 > last32) ? last32 : b32;
  assign empty  = (a32 > last32) || (a32 > bc32);

  assign in_tready  = (st_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    st_nxt   = st_r;
    clr_nxt  = clr_r;
    size_nxt = size_r;
    pass_nxt = pass_r;
    two_nxt  = two_r;
    i_nxt    = i_r;
    p_nxt    = p_r;
    a_nxt    = a_r;
    b1_nxt   = b1_r;
    val_nxt  = val_r;
    valp_nxt = valp_r;
    acc1_nxt = acc1_r;
    acc2_nxt = acc2_r;
    lo_nxt   = lo_r;
    res_nxt  = res_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    we       = 1'b0;
    waddr    = i_r[AW-1:0];
    // Add each half on its own: no carry crosses between the two trees.
    wdata    = {rdata[2*DW-1:DW] + valp_r, rdata[DW-1:0] + val_r};
    raddr    = i_r[AW-1:0];
    mul_a    = val_r[31:0];

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (st_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt    = a32[IW-1:0];
          b1_nxt   = IW'(bc32 + 32'd1);
          val_nxt  = in_tdata[83:20];
          pass_nxt = 1'b0;
          two_nxt  = (bc32 + 32'd1) < 32'(size_r);
          res_nxt  = '0;
          if (in_tuser == rars_pkg::CMD_ADD) begin
            // Difference array: +v at the low index, -v past the high index.
            p_nxt = a32[IW-1:0];
            if (!empty) begin
              st_nxt = ST_ULO;
            end
          end else begin
            p_nxt    = IW'(bc32 + 32'd1);
            i_nxt    = IW'(bc32 + 32'd1);
            acc1_nxt = '0;
            acc2_nxt = '0;
            st_nxt   = empty ? ST_OUT : ST_QRD;
          end
        end
      end
      ST_CLR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(CAPACITY)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_ULO: begin
        mul_a  = val_r[31:0];
        lo_nxt = DW'(mul_p);
        st_nxt = ST_UHI;
      end
      ST_UHI: begin
        mul_a    = val_r[63:32];
        valp_nxt = lo_r + {mul_p[31:0], 32'd0};
        i_nxt    = p_r + IW'(1);
        st_nxt   = ST_URD;
      end
      ST_URD: begin
        st_nxt = ST_UWR;
      end
      ST_UWR: begin
        we    = 1'b1;
        i_nxt = i_up;
        if (i_up > IW'(size_r)) begin
          if (!pass_r && two_r) begin
            pass_nxt = 1'b1;
            p_nxt    = b1_r;
            val_nxt  = -val_r;
            st_nxt   = ST_ULO;
          end else begin
            st_nxt = ST_IDLE;
          end
        end else begin
          st_nxt = ST_URD;
        end
      end
      ST_QRD: begin
        st_nxt = ST_QACC;
      end
      ST_QACC: begin
        acc1_nxt = acc1_r + rdata[DW-1:0];
        acc2_nxt = acc2_r + rdata[2*DW-1:DW];
        i_nxt    = i_dn;
        st_nxt   = (i_dn == '0) ? ST_QLO : ST_QRD;
      end
      ST_QLO: begin
        mul_a  = acc1_r[31:0];
        lo_nxt = DW'(mul_p);
        st_nxt = ST_QHI;
      end
      ST_QHI: begin
        // prefix(x) = x * sum(d) - sum(d * p)
        mul_a   = acc1_r[63:32];
        res_nxt = pass_r ? (res_r - pre) : pre;
        st_nxt  = ST_QFIN;
      end
      ST_QFIN: begin
        if (!pass_r) begin
          pass_nxt = 1'b1;
          p_nxt    = a_r;
          i_nxt    = a_r;
          acc1_nxt = '0;
          acc2_nxt = '0;
          st_nxt   = (a_r == '0) ? ST_QLO : ST_QRD;
        end else begin
          st_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = res_r;
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    // Size write: clamp and restart the clearing pass.
    if (cfg_valid) begin
      if (cfg32 == 32'd0) begin
        size_nxt = SW'(1);
      end else if (cfg32 > 32'(CAPACITY)) begin
        size_nxt = SW'(CAPACITY);
      end else begin
        size_nxt = cfg32[SW-1:0];
      end
      st_nxt  = ST_CLR;
      clr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_CLR;
      clr_r  <= '0;
      size_r <= SW'(CAPACITY);
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      size_r <= size_nxt;
      ov_r   <= ov_nxt;
    end
    pass_r <= pass_nxt;
    two_r  <= two_nxt;
    i_r    <= i_nxt;
    p_r    <= p_nxt;
    a_r    <= a_nxt;
    b1_r   <= b1_nxt;
    val_r  <= val_nxt;
    valp_r <= valp_nxt;
    acc1_r <= acc1_nxt;
    acc2_r <= acc2_nxt;
    lo_r   <= lo_nxt;
    res_r  <= res_nxt;
    od_r   <= od_nxt;
  end

  // A taken command that does work blocks the input for the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !cfg_valid && !(in_tuser == rars_pkg::CMD_ADD && empty)
    |=> !in_tready)
    else $error("input taken twice in a row");

  // A size write always restarts the clearing pass.
  a_cfg_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> st_r == ST_CLR && clr_r == '0)
    else $error("size write did not start a clear");

  // Size in use stays within 1..CAPACITY.
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    size_r != '0 && size_r <= SW'(CAPACITY))
    else $error("size out of range");

  // Tree walks never touch entry zero.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_URD || st_r == ST_QRD |-> i_r != '0)
    else $error("walk at index zero");

endmodule

/* sv/rars_ram.sv */
// ----------------------------------------------------------------------------
// rars_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rars_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
